// ----- hdl/nta_pkg.sv -----
// Shared types and constants of the neighbor table aging unit.
// Used by nta_engine and neighbor_table_aging_unit; depends on nothing.
`default_nettype none

package nta_pkg;

  // default table depth
  localparam int NTA_ENTRIES = 512;

  // configuration reset values
  localparam logic [7:0] NTA_AGE_RELOAD_RST = 8'd120;
  localparam logic [7:0] NTA_EXP_LEN_RST    = 8'd28;

  // configuration register indexes
  localparam logic CFG_AGE_RELOAD = 1'b0;
  localparam logic CFG_EXP_LEN    = 1'b1;

  // item function codes
  localparam logic [1:0] FUNC_MSG  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // message types
  localparam logic [7:0] MSG_ECHO = 8'd1;
  localparam logic [7:0] MSG_DOWN = 8'd2;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_LEN_ERR = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // result action codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_ADDED   = 2'd1;
  localparam logic [1:0] ACT_UPDATED = 2'd2;
  localparam logic [1:0] ACT_DELETED = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TICK,
    ST_READ,
    ST_DONE
  } nta_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  msg_type;
    logic [15:0] frame_length;
    logic [31:0] ip_address;
    logic [15:0] port_number;
    logic [63:0] name_word;
    logic [8:0]  slot_index;
  } nta_item_t;

  typedef struct packed {
    logic [7:0] age_reload;
    logic [7:0] expected_length;
  } nta_cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  action;
    logic [9:0]  neighbor_count;
    logic [9:0]  removed_count;
    logic        entry_valid;
    logic [31:0] entry_ip;
    logic [15:0] entry_port;
    logic [7:0]  entry_age;
    logic [63:0] entry_name;
  } nta_result_t;

  // one table slot as stored in memory
  typedef struct packed {
    logic        live;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  age;
    logic [63:0] name;
  } nta_entry_t;

endpackage

`default_nettype wire

// ----- hdl/nta_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; no package dependency.
`default_nettype none

module nta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/nta_engine.sv -----
// Table sequencer: clearing pass, lookup sweeps, age sweeps and slot reads over
// the table memory. Depends on nta_pkg; the memory sits outside in the top level.
`default_nettype none

module nta_engine #(
  parameter int TABLE_ENTRIES = nta_pkg::NTA_ENTRIES,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire nta_pkg::nta_item_t  in_item,
  input  wire nta_pkg::nta_cfg_t   cfg,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output nta_pkg::nta_result_t     res,
  output logic                     ram_we,
  output logic [AW-1:0]            ram_waddr,
  output nta_pkg::nta_entry_t      ram_wdata,
  output logic [AW-1:0]            ram_raddr,
  input  wire nta_pkg::nta_entry_t ram_rdata
);

  localparam int CntW = AW + 1;
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(TABLE_ENTRIES);
  localparam logic [CntW-1:0] LastCnt = CntW'(TABLE_ENTRIES - 1);

  nta_pkg::nta_state_t  state_r, state_nxt;
  logic [CntW-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic                 pipe_vld_r, pipe_vld_nxt;
  logic [AW-1:0]        pipe_idx_r, pipe_idx_nxt;
  nta_pkg::nta_item_t   item_r, item_nxt;
  logic                 match_found_r, match_found_nxt;
  logic [AW-1:0]        match_idx_r, match_idx_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [AW-1:0]        free_idx_r, free_idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        removed_r, removed_nxt;
  nta_pkg::nta_result_t res_r, res_nxt;

  logic [31:0] in_sidx_w;
  logic [31:0] item_sidx_w;

  assign in_sidx_w   = 32'(in_item.slot_index);
  assign item_sidx_w = 32'(item_r.slot_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= nta_pkg::ST_CLEAR;
      rd_cnt_r      <= '0;
      pipe_vld_r    <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      count_r       <= '0;
      removed_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      rd_cnt_r      <= rd_cnt_nxt;
      pipe_vld_r    <= pipe_vld_nxt;
      match_found_r <= match_found_nxt;
      free_found_r  <= free_found_nxt;
      count_r       <= count_nxt;
      removed_r     <= removed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx_r  <= pipe_idx_nxt;
    item_r      <= item_nxt;
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    res_r       <= res_nxt;
  end

  always_comb begin
    nta_pkg::nta_entry_t new_entry;
    nta_pkg::nta_entry_t cur;
    logic [31:0]         cnt_w;
    logic [31:0]         rem_w;
    logic                finish;

    state_nxt       = state_r;
    rd_cnt_nxt      = rd_cnt_r;
    pipe_vld_nxt    = 1'b0;
    pipe_idx_nxt    = pipe_idx_r;
    item_nxt        = item_r;
    match_found_nxt = match_found_r;
    match_idx_nxt   = match_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    count_nxt       = count_r;
    removed_nxt     = removed_r;
    res_nxt         = res_r;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = pipe_idx_r;
    ram_wdata       = '0;
    ram_raddr       = rd_cnt_r[AW-1:0];
    finish          = 1'b0;
    cur             = ram_rdata;

    new_entry.live = 1'b1;
    new_entry.ip   = item_r.ip_address;
    new_entry.port = item_r.port_number;
    new_entry.age  = cfg.age_reload;
    new_entry.name = item_r.name_word;

    unique case (state_r)
      nta_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_cnt_r[AW-1:0];
        if (rd_cnt_r == LastCnt) begin
          rd_cnt_nxt = '0;
          state_nxt  = nta_pkg::ST_IDLE;
        end else begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
      end

      nta_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = in_sidx_w[AW-1:0];
        if (in_valid) begin
          item_nxt        = in_item;
          res_nxt         = '0;
          rd_cnt_nxt      = '0;
          match_found_nxt = 1'b0;
          free_found_nxt  = 1'b0;
          removed_nxt     = '0;
          unique case (in_item.func)
            nta_pkg::FUNC_MSG: begin
              if (in_item.frame_length != {8'd0, cfg.expected_length}) begin
                res_nxt.status = nta_pkg::STAT_LEN_ERR;
                finish         = 1'b1;
                state_nxt      = nta_pkg::ST_DONE;
              end else if (in_item.msg_type == nta_pkg::MSG_ECHO ||
                           in_item.msg_type == nta_pkg::MSG_DOWN) begin
                state_nxt = nta_pkg::ST_SCAN;
              end else begin
                finish    = 1'b1;
                state_nxt = nta_pkg::ST_DONE;
              end
            end
            nta_pkg::FUNC_TICK: state_nxt = nta_pkg::ST_TICK;
            nta_pkg::FUNC_READ: state_nxt = nta_pkg::ST_READ;
            default: begin
              finish    = 1'b1;
              state_nxt = nta_pkg::ST_DONE;
            end
          endcase
        end
      end

      nta_pkg::ST_SCAN: begin
        if (rd_cnt_r != FullCnt) begin
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = rd_cnt_r[AW-1:0];
          rd_cnt_nxt   = rd_cnt_r + 1'b1;
        end
        if (pipe_vld_r) begin
          if (cur.live && cur.ip == item_r.ip_address &&
              cur.port == item_r.port_number && !match_found_r) begin
            match_found_nxt = 1'b1;
            match_idx_nxt   = pipe_idx_r;
          end
          if (!cur.live && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = pipe_idx_r;
          end
        end
        if (rd_cnt_r == FullCnt && !pipe_vld_r) begin
          finish    = 1'b1;
          state_nxt = nta_pkg::ST_DONE;
          ram_wdata = new_entry;
          if (item_r.msg_type == nta_pkg::MSG_ECHO) begin
            if (match_found_r) begin
              ram_we         = 1'b1;
              ram_waddr      = match_idx_r;
              res_nxt.action = nta_pkg::ACT_UPDATED;
            end else if (free_found_r) begin
              ram_we         = 1'b1;
              ram_waddr      = free_idx_r;
              count_nxt      = count_r + 1'b1;
              res_nxt.action = nta_pkg::ACT_ADDED;
            end else begin
              res_nxt.status = nta_pkg::STAT_FULL;
            end
          end else if (match_found_r) begin
            ram_we         = 1'b1;
            ram_waddr      = match_idx_r;
            ram_wdata.live = 1'b0;
            count_nxt      = count_r - 1'b1;
            res_nxt.action = nta_pkg::ACT_DELETED;
          end
        end
      end

      nta_pkg::ST_TICK: begin
        if (rd_cnt_r != FullCnt) begin
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = rd_cnt_r[AW-1:0];
          rd_cnt_nxt   = rd_cnt_r + 1'b1;
        end
        // write back one slot behind the read address
        if (pipe_vld_r && cur.live) begin
          ram_we    = 1'b1;
          ram_waddr = pipe_idx_r;
          ram_wdata = cur;
          if (cur.age <= 8'd1) begin
            ram_wdata.live = 1'b0;
            count_nxt      = count_r - 1'b1;
            removed_nxt    = removed_r + 1'b1;
          end else begin
            ram_wdata.age = cur.age - 8'd1;
          end
        end
        if (rd_cnt_r == FullCnt && !pipe_vld_r) begin
          finish    = 1'b1;
          state_nxt = nta_pkg::ST_DONE;
        end
      end

      nta_pkg::ST_READ: begin
        if (item_sidx_w < 32'(TABLE_ENTRIES) && cur.live) begin
          res_nxt.entry_valid = 1'b1;
          res_nxt.entry_ip    = cur.ip;
          res_nxt.entry_port  = cur.port;
          res_nxt.entry_age   = cur.age;
          res_nxt.entry_name  = cur.name;
        end
        finish    = 1'b1;
        state_nxt = nta_pkg::ST_DONE;
      end

      nta_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = nta_pkg::ST_IDLE;
        end
      end

      default: state_nxt = nta_pkg::ST_CLEAR;
    endcase

    cnt_w = 32'(count_nxt);
    rem_w = 32'(removed_nxt);
    if (finish) begin
      res_nxt.neighbor_count = cnt_w[9:0];
      res_nxt.removed_count  = rem_w[9:0];
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- hdl/neighbor_table_aging_unit.sv -----
// Top level of the neighbor table aging unit: stream ports, configuration
// registers, output register, table memory. Depends on nta_pkg, nta_ram, nta_engine.
`default_nettype none

// Neighbor table keyed by IPv4 address and UDP port, with one age timer per slot.
// Each input transaction carries a function in in_tuser: a received message
// (echo refreshes or adds an entry, down deletes it, bad length is rejected), a
// one-second age tick, or a read of one slot. Exactly one result transaction
// comes out per input transaction, in order, always carrying the live count.
// All table state sits in one memory of TABLE_ENTRIES slots with a registered
// read. After reset the block runs a clearing pass over every slot that zeroes
// its live bit; in_tready stays low until the pass ends, while configuration
// writes are taken as ever. Echo and down messages and ticks sweep every slot
// through the memory read port; a slot read reads only its one slot; rejected
// or ignored messages touch no slot. Each transaction is finished before the
// next one is accepted.
// The output register holds a finished result while the next transaction is
// taken, so a slow sink only stalls the block once a second result is ready.
// An echo that finds no match and no free slot reports table full and is
// dropped. Counts are reported modulo 1024. Write configuration only while the
// block is idle.
module neighbor_table_aging_unit #(
  parameter int TABLE_ENTRIES = nta_pkg::NTA_ENTRIES
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [7:0] msg_type, [23:8] frame_length, [55:24] ip_address,
  // [71:56] port_number, [135:72] name_word, [144:136] slot_index, rest zero
  input  wire logic [151:0] in_tdata,
  // [1:0] func
  input  wire logic [1:0]   in_tuser,
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [1:0] status, [3:2] action, [13:4] neighbor_count, [23:14] removed_count,
  // [24] entry_valid, [56:25] entry_ip, [72:57] entry_port, [80:73] entry_age,
  // [144:81] entry_name, rest zero
  output logic [151:0]      out_tdata,
  // configuration write port
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_index,
  input  wire logic [7:0]   cfg_wdata
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  nta_pkg::nta_cfg_t    cfg_r, cfg_nxt;
  nta_pkg::nta_item_t   in_item;
  nta_pkg::nta_result_t eng_res;
  logic                 eng_res_valid;
  logic                 out_load;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [151:0]         out_tdata_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  nta_pkg::nta_entry_t  ram_wdata;
  nta_pkg::nta_entry_t  ram_rdata;

  // Unpack the input transaction.
  assign in_item.func         = in_tuser;
  assign in_item.msg_type     = in_tdata[7:0];
  assign in_item.frame_length = in_tdata[23:8];
  assign in_item.ip_address   = in_tdata[55:24];
  assign in_item.port_number  = in_tdata[71:56];
  assign in_item.name_word    = in_tdata[135:72];
  assign in_item.slot_index   = in_tdata[144:136];

  // Configuration registers: take a write whenever the enable is high.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        nta_pkg::CFG_AGE_RELOAD: cfg_nxt.age_reload      = cfg_wdata;
        nta_pkg::CFG_EXP_LEN:    cfg_nxt.expected_length = cfg_wdata;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.age_reload      <= nta_pkg::NTA_AGE_RELOAD_RST;
      cfg_r.expected_length <= nta_pkg::NTA_EXP_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nta_ram #(
    .WIDTH ($bits(nta_pkg::nta_entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nta_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .res_valid (eng_res_valid),
    .res_ready (out_load),
    .res       (eng_res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Output register: load a finished result when empty or being drained.
  assign out_load = eng_res_valid && (!out_tvalid_r || out_tready);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {7'd0, eng_res.entry_name, eng_res.entry_age, eng_res.entry_port,
                      eng_res.entry_ip, eng_res.entry_valid, eng_res.removed_count,
                      eng_res.neighbor_count, eng_res.action, eng_res.status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // In the cycle after an accepted transaction the engine is still busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready stayed high after an accepted transaction");

  // An error or full status never comes with a table change.
  a_err_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != nta_pkg::STAT_OK |-> out_tdata[3:2] == nta_pkg::ACT_NONE)
    else $error("error status reported together with a table action");

  // A slot read result carries no status, action or removal.
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24] |-> out_tdata[1:0] == nta_pkg::STAT_OK &&
      out_tdata[3:2] == nta_pkg::ACT_NONE && out_tdata[23:14] == 10'd0)
    else $error("read result mixed with message or tick fields");

endmodule

`default_nettype wire
